[src/rsa_pkg.sv]
// Package for the radial spectrum averager: field widths, function and
// register codes, payload structs and reset values.
// No dependencies.
`default_nettype none

package rsa_pkg;

  localparam int MAX_BINS_DEF = 64;

  localparam int FUNC_W     = 2;
  localparam int BIN_W      = 6;
  localparam int RAD_W      = 18;
  localparam int DIST_W     = 18;
  localparam int VAL_W      = 32;
  localparam int STEP_W     = 18;
  localparam int BINS_W     = 7;
  localparam int SUM_W      = 52;
  localparam int CNT_W      = 21;
  localparam int REG_W      = 1;
  localparam int CFG_DATA_W = 18;
  localparam int DIV_CNT_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

  localparam logic [REG_W-1:0] REG_STEP = 1'b0;
  localparam logic [REG_W-1:0] REG_BINS = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 18'd256;
  localparam logic [BINS_W-1:0] BINS_RESET = 7'd64;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BIN_W-1:0]  bin_index;
    logic [RAD_W-1:0]  radius;
    logic [DIST_W-1:0] distance;
    logic [VAL_W-1:0]  sample_value;
  } item_t;

  typedef struct packed {
    logic [BIN_W-1:0] out_bin;
    logic [VAL_W-1:0] average;
    logic             empty_bin;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } acc_entry_t;

endpackage

`default_nettype wire

[src/radial_spectrum_averager.sv]
// Radial spectrum averager, top level: command sequencer over the radius
// table and the accumulator memory, plus the divider for bin means.
// Depends on rsa_pkg, rsa_radius_mem, rsa_acc_mem and rsa_divider.
//
// Usage: an item on item is taken at a clock edge with start high and busy
// low. A load word (func 0) writes one bin radius in that edge and leaves
// busy low. A sample word (func 1) walks the bins in use, one bin a cycle,
// through a read-modify-write of the sum and count memory: busy stays high
// for the whole walk (bins_in_use forced into 1..MAX_BINS). A finish word
// (func 2) walks the bins again, clears each entry and emits one result
// word per bin on result with out_valid high for one cycle, last set on the
// final bin; with that last word every bin, in use or not, is emptied. An
// empty or saturated bin is reported straight from the S_FIN state; any
// other bin waits in S_DIV for the divider, which yields one quotient bit
// per cycle. The receiver cannot stall: each result word is shown for one
// cycle only. Register writes on cfg_we take effect at once and are meant
// for idle times. Reset restores step_size 256 and bins_in_use 64 and
// empties all bins at once; the radius table holds garbage until loaded.
`default_nettype none

module radial_spectrum_averager
  import rsa_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire item_t                 item,
  output logic                       busy,
  input  wire logic                  cfg_we,
  input  wire logic [REG_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  output result_t                    result
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [8:0] MaxBins9 = 9'(MAX_BINS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SMP  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     idx_next;
  logic [STEP_W-1:0] step_size;
  logic [BINS_W-1:0] bins_in_use;
  logic [DIST_W:0]   d2;
  logic [VAL_W-1:0]  val;

  logic              accept;
  logic [8:0]        bins9;
  logic [8:0]        n9;
  logic [AW-1:0]     last_idx;
  logic              at_last;
  logic [8:0]        bidx9;
  logic [8:0]        idx9;
  logic              rad_we;

  logic [RAD_W-1:0]  rad_q;
  acc_entry_t        acc_rd;
  acc_entry_t        acc_wdata;
  logic              acc_we;
  logic              acc_clr;

  logic [RAD_W:0]    r2;
  logic              hit;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic [CNT_W-1:0]  cnt_sat;
  logic              cnt_zero;
  logic              avg_sat;

  logic              div_start;
  logic              div_done;
  logic [VAL_W-1:0]  div_q;

  logic              emit;
  logic [VAL_W-1:0]  emit_avg;
  logic              emit_empty;

  assign busy   = state != S_IDLE;
  assign accept = start && !busy;

  // bins in use, forced into 1..MAX_BINS
  assign bins9    = 9'(bins_in_use);
  assign n9       = (bins_in_use == '0) ? 9'd1 : ((bins9 > MaxBins9) ? MaxBins9 : bins9);
  assign last_idx = AW'(n9 - 9'd1);
  assign at_last  = idx == last_idx;
  assign idx9     = 9'(idx);

  assign bidx9  = 9'(item.bin_index);
  assign rad_we = accept && (item.func == FUNC_LOAD) && (bidx9 < MaxBins9);

  // empty bins beyond the ones in use too, once the last word goes out
  assign acc_clr = emit && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size   <= STEP_RESET;
      bins_in_use <= BINS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP: step_size   <= cfg_data[STEP_W-1:0];
        REG_BINS: bins_in_use <= cfg_data[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // read address follows the next index, so read data matches idx
  rsa_radius_mem #(
    .DEPTH (MAX_BINS),
    .AW    (AW)
  ) u_radius (
    .clk   (clk),
    .we    (rad_we),
    .waddr (bidx9[AW-1:0]),
    .wdata (item.radius),
    .raddr (idx_next),
    .rdata (rad_q)
  );

  rsa_acc_mem #(
    .DEPTH (MAX_BINS),
    .AW    (AW)
  ) u_acc (
    .clk   (clk),
    .rst   (rst),
    .clr   (acc_clr),
    .we    (acc_we),
    .waddr (idx),
    .wdata (acc_wdata),
    .raddr (idx_next),
    .rdata (acc_rd)
  );

  rsa_divider u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .rem_init    (CNT_W'(acc_rd.sum[SUM_W-1:VAL_W])),
    .dividend_lo (acc_rd.sum[VAL_W-1:0]),
    .divisor     (acc_rd.cnt),
    .done        (div_done),
    .quotient    (div_q)
  );

  // ring test on doubled values: 2d + step >= 2r and 2d < 2r + step
  assign r2  = {rad_q, 1'b0};
  assign hit = (({1'b0, d2} + (RAD_W + 2)'(step_size)) >= {1'b0, r2}) &&
               ({1'b0, d2} < ({1'b0, r2} + (RAD_W + 2)'(step_size)));

  assign sum_add  = (SUM_W + 1)'(acc_rd.sum) + (SUM_W + 1)'(val);
  assign sum_sat  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
  assign cnt_sat  = (acc_rd.cnt == CNT_MAX) ? acc_rd.cnt : acc_rd.cnt + CNT_W'(1);
  assign cnt_zero = acc_rd.cnt == '0;
  // the mean overflows VAL_W bits exactly when sum / 2^VAL_W >= count
  assign avg_sat  = CNT_W'(acc_rd.sum[SUM_W-1:VAL_W]) >= acc_rd.cnt;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    acc_we     = 1'b0;
    acc_wdata  = acc_rd;
    div_start  = 1'b0;
    emit       = 1'b0;
    emit_avg   = '0;
    emit_empty = 1'b0;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
        if (accept) begin
          unique case (item.func)
            FUNC_SAMPLE: state_next = S_SMP;
            FUNC_FINISH: state_next = S_FIN;
            default: ;
          endcase
        end
      end
      S_SMP: begin
        if (hit) begin
          acc_we        = 1'b1;
          acc_wdata.sum = sum_sat;
          acc_wdata.cnt = cnt_sat;
        end
        if (at_last) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      S_FIN: begin
        // clear the entry as it is reported
        acc_we    = 1'b1;
        acc_wdata = '0;
        if (cnt_zero) begin
          emit       = 1'b1;
          emit_empty = 1'b1;
        end else if (avg_sat) begin
          emit     = 1'b1;
          emit_avg = '1;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
        if (emit) begin
          if (at_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + AW'(1);
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          emit     = 1'b1;
          emit_avg = div_q;
          if (at_last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_FIN;
            idx_next   = idx + AW'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d2  <= {item.distance, 1'b0};
      val <= item.sample_value;
    end
    if (emit) begin
      result.out_bin   <= idx9[BIN_W-1:0];
      result.average   <= emit_avg;
      result.empty_bin <= emit_empty;
      result.last      <= at_last;
    end
  end

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($past(state) == S_FIN || $past(state) == S_DIV))
    else $error("result word outside a finish walk");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.last) |-> !busy)
    else $error("still busy after the last result word");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.empty_bin) |-> (result.average == '0))
    else $error("empty bin with nonzero average");

endmodule

`default_nettype wire

[src/rsa_radius_mem.sv]
// Bin radius table: one write port, one registered read port.
// Depends on rsa_pkg.
`default_nettype none

module rsa_radius_mem
  import rsa_pkg::*;
#(
  parameter int DEPTH = MAX_BINS_DEF,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [RAD_W-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [RAD_W-1:0] rdata
);

  logic [RAD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/rsa_acc_mem.sv]
// Per-bin sum and count memory with registered read; valid bits make
// entries read as zero after reset or a clear until first written.
// Depends on rsa_pkg.
`default_nettype none

module rsa_acc_mem
  import rsa_pkg::*;
#(
  parameter int DEPTH = MAX_BINS_DEF,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clr,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire acc_entry_t    wdata,
  input  wire logic [AW-1:0] raddr,
  output acc_entry_t         rdata
);

  acc_entry_t       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  acc_entry_t       raw;
  logic             raw_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      raw_valid <= 1'b0;
    end else begin
      // drop every entry at once; a write in the same cycle only clears
      if (clr) begin
        valid <= '0;
      end else if (we) begin
        valid[waddr] <= 1'b1;
      end
      raw_valid <= valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    raw <= mem[raddr];
  end

  assign rdata = raw_valid ? raw : '0;

endmodule

`default_nettype wire

[src/rsa_divider.sv]
// Restoring divider, one quotient bit per cycle, for a quotient known to
// fit VAL_W bits (remainder start below the divisor).
// Depends on rsa_pkg.
`default_nettype none

module rsa_divider
  import rsa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [CNT_W-1:0] rem_init,
  input  wire logic [VAL_W-1:0] dividend_lo,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic      [VAL_W-1:0] quotient
);

  logic                 running;
  logic [DIV_CNT_W-1:0] step_cnt;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     divisor_q;
  logic [VAL_W-1:0]     shreg;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 ge;
  logic [CNT_W-1:0]     rem_next;

  assign trial    = {rem, shreg[VAL_W-1]};
  assign ge       = trial >= {1'b0, divisor_q};
  assign diff     = trial - {1'b0, divisor_q};
  assign rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        step_cnt <= '0;
      end else if (running) begin
        if (step_cnt == DIV_CNT_W'(VAL_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        step_cnt <= step_cnt + DIV_CNT_W'(1);
      end
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem       <= rem_init;
      shreg     <= dividend_lo;
      divisor_q <= divisor;
    end else if (running) begin
      rem   <= rem_next;
      shreg <= {shreg[VAL_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking bench for radial_spectrum_averager: a directed table, then
// random load/sample/finish runs checked against a ring-average predictor.
// Depends on rsa_pkg and the radial_spectrum_averager RTL.
`default_nettype none

module tb;
  import rsa_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    bit                    is_cfg;
    logic [REG_W-1:0]      reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [FUNC_W-1:0]     func;
    logic [BIN_W-1:0]      bin_index;
    logic [RAD_W-1:0]      radius;
    logic [DIST_W-1:0]     distance;
    logic [VAL_W-1:0]      sample_value;
    bit                    typed;
    logic [VAL_W-1:0]      mean;
    bit                    empty;
  } plan_row_t;

  localparam int PLAN_LEN = 24;
  // typed rows run with one bin in use, so they give one word for bin 0
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // cfg  reg       value       func         bin    radius      distance    value
    '{1'b0, REG_STEP, 18'd0,      FUNC_FINISH, 6'd0,  18'd0,      18'd0,      32'd0,
      1'b0, 32'd0, 1'b0},
    '{1'b1, REG_BINS, 18'd0,      FUNC_LOAD,   6'd0,  18'd0,      18'd0,      32'd0,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_FINISH, 6'd0,  18'd0,      18'd0,      32'd0,
      1'b1, 32'd0, 1'b1},
    '{1'b0, REG_STEP, 18'd0,      FUNC_LOAD,   6'd0,  18'd0,      18'd0,      32'd0,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_SAMPLE, 6'd0,  18'd0,      18'd0,      32'hFFFFFFFF,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_SAMPLE, 6'd0,  18'd0,      18'd127,    32'd1,
      1'b0, 32'd0, 1'b0},
    // upper ring edge is exclusive
    '{1'b0, REG_STEP, 18'd0,      FUNC_SAMPLE, 6'd0,  18'd0,      18'd128,    32'd5,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_FINISH, 6'd0,  18'd0,      18'd0,      32'd0,
      1'b1, 32'h80000000, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_SPARE,  6'd63, 18'h3FFFF,  18'h3FFFF,  32'hFFFFFFFF,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_LOAD,   6'd0,  18'h3FFFF,  18'd0,      32'd0,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_SAMPLE, 6'd0,  18'd0,      18'h3FFFF,  32'hFFFFFFFF,
      1'b0, 32'd0, 1'b0},
    // lower ring edge is inclusive
    '{1'b0, REG_STEP, 18'd0,      FUNC_SAMPLE, 6'd0,  18'd0,      18'h3FF7F,  32'd0,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_SAMPLE, 6'd0,  18'd0,      18'd0,      32'd7,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_FINISH, 6'd0,  18'd0,      18'd0,      32'd0,
      1'b1, 32'h7FFFFFFF, 1'b0},
    '{1'b1, REG_STEP, 18'd0,      FUNC_LOAD,   6'd0,  18'd0,      18'd0,      32'd0,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_SAMPLE, 6'd0,  18'd0,      18'h3FFFF,  32'd3,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_FINISH, 6'd0,  18'd0,      18'd0,      32'd0,
      1'b1, 32'd0, 1'b1},
    '{1'b1, REG_STEP, 18'h3FFFF,  FUNC_LOAD,   6'd0,  18'd0,      18'd0,      32'd0,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_SAMPLE, 6'd0,  18'd0,      18'h20000,  32'h12345678,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_SAMPLE, 6'd0,  18'd0,      18'd0,      32'd9,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_FINISH, 6'd0,  18'd0,      18'd0,      32'd0,
      1'b1, 32'h12345678, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_LOAD,   6'd63, 18'h2AAAA,  18'd0,      32'd0,
      1'b0, 32'd0, 1'b0},
    // bin count above the table size clamps to the full table
    '{1'b1, REG_BINS, 18'd127,    FUNC_LOAD,   6'd0,  18'd0,      18'd0,      32'd0,
      1'b0, 32'd0, 1'b0},
    '{1'b0, REG_STEP, 18'd0,      FUNC_FINISH, 6'd0,  18'd0,      18'd0,      32'd0,
      1'b0, 32'd0, 1'b0}
  };

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  item_t                 item = '0;
  logic                  busy;
  logic                  cfg_we = 1'b0;
  logic [REG_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  out_valid;
  result_t               result;

  radial_spectrum_averager dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .result    (result)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // predictor state
  logic [STEP_W-1:0] step_reg = STEP_RESET;
  logic [BINS_W-1:0] bins_reg = BINS_RESET;
  logic [RAD_W-1:0]  ring_radius [MAX_BINS_DEF];
  logic [SUM_W-1:0]  ring_sum    [MAX_BINS_DEF];
  logic [CNT_W-1:0]  ring_cnt    [MAX_BINS_DEF];
  result_t           expected_means [$];

  int idle_pct = 31;
  int mismatches = 0;
  int results_seen = 0;
  int loads_sent = 0;
  int samples_sent = 0;
  int finishes_sent = 0;
  int ignored_sent = 0;

  function automatic int live_bins();
    int n;
    n = int'(bins_reg);
    if (n == 0) n = 1;
    if (n > MAX_BINS_DEF) n = MAX_BINS_DEF;
    return n;
  endfunction

  task automatic predict_ring_word(input item_t w);
    int n;
    logic [19:0] d2;
    logic [19:0] r2;
    logic [19:0] st;
    logic [SUM_W:0] s;
    logic [SUM_W-1:0] q;
    result_t r;
    n = live_bins();
    case (w.func)
      FUNC_LOAD: ring_radius[w.bin_index] = w.radius;
      FUNC_SAMPLE: begin
        d2 = {1'b0, w.distance, 1'b0};
        st = {2'b00, step_reg};
        for (int b = 0; b < n; b++) begin
          r2 = {1'b0, ring_radius[b], 1'b0};
          // doubled compare keeps the ring edges exact
          if (d2 + st >= r2 && d2 < r2 + st) begin
            s = {1'b0, ring_sum[b]} + {21'd0, w.sample_value};
            ring_sum[b] = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
            if (ring_cnt[b] != CNT_MAX) ring_cnt[b] = ring_cnt[b] + 1'b1;
          end
        end
      end
      FUNC_FINISH: begin
        for (int b = 0; b < n; b++) begin
          q = (ring_cnt[b] == '0) ? '0 : ring_sum[b] / SUM_W'(ring_cnt[b]);
          r.out_bin   = BIN_W'(b);
          r.average   = (q > SUM_W'(32'hFFFFFFFF)) ? '1 : q[VAL_W-1:0];
          r.empty_bin = (ring_cnt[b] == '0);
          r.last      = (b == n - 1);
          expected_means.push_back(r);
        end
        for (int b = 0; b < MAX_BINS_DEF; b++) begin
          ring_sum[b] = '0;
          ring_cnt[b] = '0;
        end
      end
      default: ;
    endcase
  endtask

  // present one word, hold it until taken, then fold it into the predictor
  task automatic send_word(input item_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
    predict_ring_word(w);
    case (w.func)
      FUNC_LOAD:   loads_sent++;
      FUNC_SAMPLE: samples_sent++;
      FUNC_FINISH: finishes_sent++;
      default:     ignored_sent++;
    endcase
  endtask

  // drop start, drain pending words and let a trailing sample walk finish
  task automatic settle();
    start <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_STEP) step_reg = val[STEP_W-1:0];
    else bins_reg = val[BINS_W-1:0];
    @(posedge clk);
  endtask

  task automatic retune();
    logic [CFG_DATA_W-1:0] st;
    logic [BINS_W-1:0] nb;
    case ($urandom_range(0, 3))
      0:       st = CFG_DATA_W'($urandom_range(0, 63));
      3:       st = CFG_DATA_W'($urandom_range(0, 262143));
      default: st = CFG_DATA_W'($urandom_range(64, 3000));
    endcase
    case ($urandom_range(0, 5))
      0:       nb = 7'd0;
      1:       nb = 7'd1;
      2:       nb = 7'd64;
      3:       nb = BINS_W'($urandom_range(65, 127));
      default: nb = BINS_W'($urandom_range(2, 63));
    endcase
    settle();
    write_reg(REG_STEP, st);
    // upper data bits are don't-care for the bin count
    write_reg(REG_BINS, {11'($urandom_range(0, 2047)), BINS_W'(0)} | CFG_DATA_W'(nb));
  endtask

  function automatic item_t noise_word();
    item_t w;
    w.func         = FUNC_W'($urandom);
    w.bin_index    = BIN_W'($urandom);
    w.radius       = RAD_W'($urandom);
    w.distance     = DIST_W'($urandom);
    w.sample_value = $urandom;
    return w;
  endfunction

  function automatic item_t load_word(input int b);
    item_t w;
    w = noise_word();
    w.func = FUNC_LOAD;
    w.bin_index = BIN_W'(b);
    // keep most radii close together so rings overlap and catch samples
    if ($urandom_range(0, 7) == 0) w.radius = RAD_W'($urandom);
    else w.radius = RAD_W'($urandom_range(0, 8000));
    return w;
  endfunction

  function automatic item_t sample_word();
    item_t w;
    int t;
    int span;
    int d;
    w = noise_word();
    w.func = FUNC_SAMPLE;
    if ($urandom_range(0, 4) != 0) begin
      // aim at a live ring, a little past its edges either way
      t = $urandom_range(0, live_bins() - 1);
      span = int'(step_reg) + 8;
      d = int'(ring_radius[t]) + int'($urandom_range(0, span)) - span / 2;
      if (d < 0) d = 0;
      if (d > 262143) d = 262143;
      w.distance = DIST_W'(d);
    end
    if ($urandom_range(0, 3) == 0) w.sample_value = $urandom_range(0, 1000);
    return w;
  endfunction

  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && out_valid) begin
      if (expected_means.size() == 0) begin
        $error("result word for bin %0d with nothing pending", result.out_bin);
        mismatches++;
      end else begin
        want = expected_means.pop_front();
        results_seen++;
        if (result.out_bin !== want.out_bin) begin
          $error("out_bin expected %0d got %0d", want.out_bin, result.out_bin);
          mismatches++;
        end
        if (result.average !== want.average) begin
          $error("average expected %h got %h", want.average, result.average);
          mismatches++;
        end
        if (result.empty_bin !== want.empty_bin) begin
          $error("empty_bin expected %b got %b", want.empty_bin, result.empty_bin);
          mismatches++;
        end
        if (result.last !== want.last) begin
          $error("last expected %b got %b", want.last, result.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    plan_row_t row;
    item_t w;
    result_t typed_mean;
    int goal;
    int base;
    for (int b = 0; b < MAX_BINS_DEF; b++) begin
      ring_radius[b] = '0;
      ring_sum[b] = '0;
      ring_cnt[b] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      row = PLAN[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        w = '{row.func, row.bin_index, row.radius, row.distance, row.sample_value};
        send_word(w);
        if (row.typed) begin
          void'(expected_means.pop_back());
          typed_mean = '{BIN_W'(0), row.mean, row.empty, 1'b1};
          expected_means.push_back(typed_mean);
        end
      end
    end

    base = loads_sent + samples_sent + finishes_sent;
    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 31 : (p == 1) ? 84 : 0;
      goal = base + MAX_BINS_DEF + (p + 1) * 30;
      retune();
      // every ring gets a radius before any sample can test it
      if (p == 0)
        for (int b = 0; b < MAX_BINS_DEF; b++) send_word(load_word(b));
      while (loads_sent + samples_sent + finishes_sent < goal) begin
        if ($urandom_range(0, 2) == 0) retune();
        repeat ($urandom_range(0, 3)) send_word(load_word($urandom_range(0, 63)));
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 7) == 0) begin
            w = noise_word();
            w.func = FUNC_SPARE;
            send_word(w);
          end
          send_word(sample_word());
        end
        // now and then skip the finish so sums carry into the next run
        if ($urandom_range(0, 5) != 0) begin
          w = noise_word();
          w.func = FUNC_FINISH;
          send_word(w);
        end
      end
    end

    start <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d loads, %0d samples, %0d finishes and %0d ignored words",
             loads_sent, samples_sent, finishes_sent, ignored_sent);
    $display("checked %0d bin averages over several step and bin settings", results_seen);
    if (mismatches == 0) begin
      $display("radial_spectrum_averager verification clean");
    end else begin
      $display("radial_spectrum_averager verification failed");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("radial_spectrum_averager verification failed");
    $finish;
  end

endmodule

`default_nettype wire
